FILE: hdl/ippf_pkg.sv
// Package: shared constants and types for the IPv4 port packet filter.
`timescale 1ns / 1ps

package ippf_pkg;

	localparam int unsigned CntW = 7;
	localparam logic [CntW-1:0] CountMax = 7'd127;

	localparam logic [CntW-1:0] PosTypeHi = 7'd12;
	localparam logic [CntW-1:0] PosTypeLo = 7'd13;
	localparam logic [CntW-1:0] PosIhl = 7'd14;
	localparam logic [CntW-1:0] PosProto = 7'd23;

	localparam logic [CntW-1:0] EthHdrLen = 7'd14;
	localparam logic [7:0] MinLenEth = 8'd14;
	localparam logic [7:0] MinLenIp = 8'd34;
	localparam logic [7:0] TcpHdrLen = 8'd20;
	localparam logic [7:0] UdpHdrLen = 8'd8;

	localparam logic [15:0] TypeIpv4 = 16'h0800;
	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;
	localparam logic [15:0] PortReset = 16'd8000;

	// one frame byte leaving the input register
	typedef struct packed {
		logic advance;
		logic last;
		logic [7:0] data;
	} step_t;

endpackage

FILE: hdl/ippf_if.sv
// Interfaces: frame byte channel and verdict channel.
`timescale 1ns / 1ps

interface ippf_in_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ippf_out_if;
	logic valid;
	logic ready;
	logic pass_frame;

	modport source (output valid, output pass_frame, input ready);
	modport sink (input valid, input pass_frame, output ready);
endinterface

FILE: hdl/ippf_capture.sv
// Frame state: byte counter, header field capture and verdict logic.
`timescale 1ns / 1ps

module ippf_capture (
	input  logic clk,
	input  logic arst_n,
	input  ippf_pkg::step_t step,
	input  logic [15:0] match_port,
	output logic verdict
);

	logic [ippf_pkg::CntW-1:0] byte_count_q;
	logic [15:0] ether_type_q;
	logic [3:0] header_words_q;
	logic [7:0] proto_id_q;
	logic [15:0] source_port_q;
	logic [15:0] dest_port_q;

	logic [ippf_pkg::CntW-1:0] pos;
	logic [ippf_pkg::CntW-1:0] tstart;
	logic [15:0] ether_type_n;
	logic [3:0] header_words_n;
	logic [7:0] proto_id_n;
	logic [15:0] source_port_n;
	logic [15:0] dest_port_n;
	logic [7:0] len;
	logic [7:0] need;
	logic proto_ok;

	always_comb begin
		pos = byte_count_q;
		ether_type_n = ether_type_q;
		header_words_n = header_words_q;
		proto_id_n = proto_id_q;
		source_port_n = source_port_q;
		dest_port_n = dest_port_q;

		if (pos == ippf_pkg::PosTypeHi) ether_type_n[15:8] = step.data;
		if (pos == ippf_pkg::PosTypeLo) ether_type_n[7:0] = step.data;
		if (pos == ippf_pkg::PosIhl) header_words_n = step.data[3:0];
		if (pos == ippf_pkg::PosProto) proto_id_n = step.data;

		// the length nibble of this byte already moves the transport start
		tstart = ippf_pkg::EthHdrLen + {1'b0, header_words_n, 2'b00};
		if (pos == tstart) source_port_n[15:8] = step.data;
		if (pos == tstart + 7'd1) source_port_n[7:0] = step.data;
		if (pos == tstart + 7'd2) dest_port_n[15:8] = step.data;
		if (pos == tstart + 7'd3) dest_port_n[7:0] = step.data;

		len = {1'b0, pos} + 8'd1;
		proto_ok = 1'b1;
		priority if (proto_id_n == ippf_pkg::ProtoTcp) begin
			need = ippf_pkg::TcpHdrLen;
		end else if (proto_id_n == ippf_pkg::ProtoUdp) begin
			need = ippf_pkg::UdpHdrLen;
		end else begin
			need = 8'd0;
			proto_ok = 1'b0;
		end

		verdict = (len >= ippf_pkg::MinLenEth) && (ether_type_n == ippf_pkg::TypeIpv4) &&
			(len >= ippf_pkg::MinLenIp) && proto_ok &&
			(len >= {1'b0, tstart} + need) &&
			((source_port_n == match_port) || (dest_port_n == match_port));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			ether_type_q <= '0;
			header_words_q <= '0;
			proto_id_q <= '0;
			source_port_q <= '0;
			dest_port_q <= '0;
		end else if (step.advance) begin
			if (step.last) begin
				byte_count_q <= '0;
				ether_type_q <= '0;
				header_words_q <= '0;
				proto_id_q <= '0;
				source_port_q <= '0;
				dest_port_q <= '0;
			end else begin
				if (byte_count_q != ippf_pkg::CountMax) byte_count_q <= byte_count_q + 7'd1;
				ether_type_q <= ether_type_n;
				header_words_q <= header_words_n;
				proto_id_q <= proto_id_n;
				source_port_q <= source_port_n;
				dest_port_q <= dest_port_n;
			end
		end
	end

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && step.last |=> byte_count_q == '0 && header_words_q == '0)
		else $error("frame state not cleared after last byte");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && !step.last && byte_count_q != ippf_pkg::CountMax
		|=> byte_count_q == $past(byte_count_q) + 7'd1)
		else $error("byte counter did not advance");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step.advance |=> $stable(byte_count_q))
		else $error("byte counter moved without a byte");

endmodule

FILE: hdl/ipv4_port_packet_filter.sv
// Top level: IPv4 TCP/UDP port filter with input register and verdict register.
//
//  channel   kind      payload                         when it moves
//  frame     sink      frame_byte[7:0], frame_end      valid & ready, one word a cycle unless stalled
//  verdict   source    pass_frame                      valid & ready, one per frame
//  cfg       write     cfg_wr_data[15:0] (match_port)  cfg_wr_en high
//
// One word is taken every cycle unless a last word waits for the verdict slot.
// A word is held in the input register, the header capture and verdict logic
// works on it there, and the verdict of a last word lands in the output register.
// Reset clears the frame state and the valid flags; match_port returns to 8000.
// A verdict left waiting does not stop the bytes of the next frame; only the
// next last word waits in the input register until the verdict is taken.
`timescale 1ns / 1ps

module ipv4_port_packet_filter (
	input  logic clk,
	input  logic arst_n,
	ippf_in_if.sink frame,
	ippf_out_if.source verdict,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [15:0] match_port_q;

	// input register
	logic s1_valid_s1;
	logic [7:0] s1_byte_s1;
	logic s1_end_s1;

	// output register
	logic out_valid_q;
	logic pass_q;

	logic out_free;
	logic advance;
	logic verdict_comb;
	ippf_pkg::step_t step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q <= ippf_pkg::PortReset;
		end else if (cfg_wr_en) begin
			match_port_q <= cfg_wr_data;
		end
	end

	// a last word may leave stage 1 only when the verdict slot is empty or frees this cycle
	assign out_free = !out_valid_q || verdict.ready;
	assign advance = s1_valid_s1 && (!s1_end_s1 || out_free);
	assign frame.ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			s1_valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			s1_byte_s1 <= frame.frame_byte;
			s1_end_s1 <= frame.frame_end;
		end
	end

	assign step.advance = advance;
	assign step.last = s1_end_s1;
	assign step.data = s1_byte_s1;

	ippf_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.match_port (match_port_q),
		.verdict    (verdict_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && s1_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_end_s1) pass_q <= verdict_comb;
	end

	assign verdict.valid = out_valid_q;
	assign verdict.pass_frame = pass_q;

	a_end_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_end_s1 |=> out_valid_q)
		else $error("last word left stage 1 without a verdict");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready |=> $stable(pass_q))
		else $error("waiting verdict overwritten");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!frame.ready |-> s1_valid_s1 && s1_end_s1 && out_valid_q)
		else $error("input stalled with no pending verdict");

	a_drop_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(verdict.ready))
		else $error("verdict withdrawn before it was taken");

endmodule
